// ----- hdl/lavm_pkg.sv -----
`timescale 1ns / 1ps
// lavm_pkg: transaction types, widths and codes of the look-at view matrix unit.
// No dependencies; imported by every lavm module except lavm_queue.
package lavm_pkg;

   localparam int ELEM_W = 32;
   localparam int VEC_W  = 18;
   localparam int UVEC_W = 19;
   localparam int RAW_W  = 50;

   localparam logic signed [ELEM_W-1:0] Q_ONE = 32'sd65536;
   localparam logic [1:0] LAST_ROW = 2'd3;

   typedef struct packed {
      logic signed [31:0] eye_x;
      logic signed [31:0] eye_y;
      logic signed [31:0] eye_z;
      logic signed [31:0] target_x;
      logic signed [31:0] target_y;
      logic signed [31:0] target_z;
      logic signed [31:0] up_x;
      logic signed [31:0] up_y;
      logic signed [31:0] up_z;
   } req_type;

   typedef struct packed {
      logic [1:0]         row_index;
      logic signed [31:0] elem0;
      logic signed [31:0] elem1;
      logic signed [31:0] elem2;
      logic signed [31:0] elem3;
      logic               last_row;
      logic               degenerate;
   } rsp_type;

   typedef struct packed {
      logic [2:0][31:0] eye;
      logic [2:0][31:0] up;
      logic [2:0][32:0] dvec;
      logic             dzero;
   } item_type;

   typedef struct packed {
      logic [2:0][VEC_W-1:0]  s;
      logic [2:0][UVEC_W-1:0] u;
      logic [2:0][VEC_W-1:0]  f;
      logic [2:0][ELEM_W-1:0] t;
      logic                   deg;
   } matrix_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NLOAD,
      ST_NSHIFT,
      ST_MAC,
      ST_SQRT,
      ST_DIV,
      ST_DONE
   } eng_state_type;

   typedef enum logic [1:0] {
      PROG_SQ,
      PROG_CROSS,
      PROG_UVEC
   } prog_type;

   typedef enum logic [1:0] {
      DST_SQ,
      DST_C,
      DST_U,
      DST_T
   } dst_type;

   typedef struct packed {
      logic       valid;
      dst_type    dst;
      logic [1:0] idx;
      logic       neg;
      logic       first;
      logic       last;
   } mac_tag_type;

endpackage

// ----- hdl/lavm_front.sv -----
`timescale 1ns / 1ps
// lavm_front: accepts request transactions, forms target - eye and flags a zero view vector.
// Depends on lavm_pkg.
module lavm_front (
   input  logic              push,
   output logic              full,
   input  lavm_pkg::req_type req_data,
   output logic              q_push,
   output lavm_pkg::item_type q_item,
   input  logic              q_full
);
   import lavm_pkg::*;

   always_comb begin
      q_item.eye[0]  = req_data.eye_x;
      q_item.eye[1]  = req_data.eye_y;
      q_item.eye[2]  = req_data.eye_z;
      q_item.up[0]   = req_data.up_x;
      q_item.up[1]   = req_data.up_y;
      q_item.up[2]   = req_data.up_z;
      q_item.dvec[0] = 33'(req_data.target_x) - 33'(req_data.eye_x);
      q_item.dvec[1] = 33'(req_data.target_y) - 33'(req_data.eye_y);
      q_item.dvec[2] = 33'(req_data.target_z) - 33'(req_data.eye_z);
      q_item.dzero   = (q_item.dvec[0] == '0) && (q_item.dvec[1] == '0)
                       && (q_item.dvec[2] == '0);
   end

   assign q_push = push;
   assign full   = q_full;

endmodule

// ----- hdl/lavm_queue.sv -----
`timescale 1ns / 1ps
// lavm_queue: small register queue between the front and the engine.
// No dependencies.
module lavm_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_valid,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   output logic             rd_valid,
   output logic [WIDTH-1:0] rd_data,
   input  logic             rd_pop
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wp_ff, wp_in, rp_ff, rp_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full     = (cnt_ff == CW'(DEPTH));
   assign rd_valid = (cnt_ff != '0);
   assign rd_data  = mem_ff[rp_ff];
   assign do_push  = wr_valid && !full;
   assign do_pop   = rd_pop && rd_valid;

   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wp_in = (wp_ff == PW'(DEPTH - 1)) ? '0 : wp_ff + 1'b1;
      end
      if (do_pop) begin
         rp_in = (rp_ff == PW'(DEPTH - 1)) ? '0 : rp_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wp_ff] <= wr_data;
      end
   end

endmodule

// ----- hdl/lavm_engine.sv -----
`timescale 1ns / 1ps
// lavm_engine: sequencer that normalizes f and s, forms u and the translation column.
// Shared multiplier-accumulator, bitwise square root and restoring divider. Depends on lavm_pkg.
module lavm_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   input  lavm_pkg::item_type    item,
   output logic                  item_pop,
   output logic                  mat_valid,
   output lavm_pkg::matrix_type  mat,
   input  logic                  mat_ready
);
   import lavm_pkg::*;

   localparam int MUL_W = 33;
   localparam int ACC_W = 64;
   localparam int SQ_W  = 62;
   localparam int LEN_W = 31;
   localparam int NUM_W = 47;
   localparam int Q_W   = 17;
   localparam int MAG_W = 30;
   localparam logic [4:0] DIV_TOP     = 5'd16;
   localparam logic [3:0] SQ_STEPS    = 4'd3;
   localparam logic [3:0] CROSS_STEPS = 4'd6;
   localparam logic [3:0] UVEC_STEPS  = 4'd15;

   eng_state_type state_ff, state_in;
   prog_type      prog_ff, prog_in;
   logic [3:0]    step_ff, step_in;
   logic          sel_ff, sel_in;
   logic signed [31:0]       eye_ff [3], eye_in [3];
   logic signed [31:0]       up_ff [3], up_in [3];
   logic signed [RAW_W-1:0]  raw_ff [3], raw_in [3];
   logic [RAW_W-1:0]         mag_ff [3], mag_in [3];
   logic                     neg_ff [3], neg_in [3];
   logic signed [VEC_W-1:0]  f_ff [3], f_in [3];
   logic signed [VEC_W-1:0]  s_ff [3], s_in [3];
   logic signed [UVEC_W-1:0] u_ff [3], u_in [3];
   logic signed [ELEM_W-1:0] t_ff [3], t_in [3];
   logic          deg_ff, deg_in;
   logic [SQ_W-1:0]  n_ff, n_in;
   logic [SQ_W:0]    r_ff, r_in, b_ff, b_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [1:0]       comp_ff, comp_in;
   logic [4:0]       qpos_ff, qpos_in;
   logic [NUM_W-1:0] rem_ff, rem_in;
   logic [Q_W-1:0]   q_ff, q_in;
   logic signed [ACC_W-1:0] prod_ff, prod_in, acc_ff, acc_in;
   mac_tag_type      tag_ff, tag_in;

   logic signed [MUL_W-1:0]   mul_a, mul_b;
   logic signed [2*MUL_W-1:0] mul_p;
   mac_tag_type               itag;
   logic [3:0]                nsteps;
   logic [1:0]                ka, kb, kk, cnext;
   logic signed [ACC_W-1:0]   base, acc_next;
   logic signed [48:0]        rnd;
   logic signed [49:0]        rnd50;
   logic [RAW_W-1:0]          or_all;
   logic [SQ_W:0]             rb;
   logic [NUM_W:0]            trial;
   logic                      ge;
   logic [Q_W-1:0]            qn;
   logic signed [VEC_W-1:0]   oval;

   function automatic logic [1:0] cross_a(input logic [2:0] k);
      logic [1:0] r;
      case (k)
         3'd0: r = 2'd1;
         3'd1: r = 2'd2;
         3'd2: r = 2'd2;
         3'd3: r = 2'd0;
         3'd4: r = 2'd0;
         3'd5: r = 2'd1;
         default: r = 2'd0;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] cross_b(input logic [2:0] k);
      logic [1:0] r;
      case (k)
         3'd0: r = 2'd2;
         3'd1: r = 2'd1;
         3'd2: r = 2'd0;
         3'd3: r = 2'd2;
         3'd4: r = 2'd1;
         3'd5: r = 2'd0;
         default: r = 2'd0;
      endcase
      return r;
   endfunction

   // round half away from zero, dropping 16 fraction bits
   function automatic logic signed [48:0] round16(input logic signed [ACC_W-1:0] v);
      logic [ACC_W-1:0] m;
      logic [47:0]      q;
      m = v[ACC_W-1] ? -v : v;
      q = 48'((m + 64'd32768) >> 16);
      return v[ACC_W-1] ? -$signed({1'b0, q}) : $signed({1'b0, q});
   endfunction

   function automatic logic signed [ELEM_W-1:0] sat32(input logic signed [49:0] v);
      logic signed [ELEM_W-1:0] r;
      if (v > 50'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -50'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[ELEM_W-1:0];
      end
      return r;
   endfunction

   function automatic logic [NUM_W-1:0] div_num(input logic [LEN_W-1:0] len,
                                                input logic [MAG_W-1:0] m);
      return {1'b0, m, 16'b0} + {17'b0, len[LEN_W-1:1]};
   endfunction

   // operand select of the shared multiplier
   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      itag   = '0;
      nsteps = SQ_STEPS;
      ka     = cross_a(step_ff[2:0]);
      kb     = cross_b(step_ff[2:0]);
      kk     = 2'd0;
      case (prog_ff)
         PROG_SQ: begin
            nsteps     = SQ_STEPS;
            kk         = step_ff[1:0];
            mul_a      = MUL_W'({1'b0, mag_ff[kk][MAG_W-1:0]});
            mul_b      = MUL_W'({1'b0, mag_ff[kk][MAG_W-1:0]});
            itag.dst   = DST_SQ;
            itag.first = (kk == 2'd0);
            itag.last  = (kk == 2'd2);
         end
         PROG_CROSS: begin
            nsteps     = CROSS_STEPS;
            mul_a      = MUL_W'(f_ff[ka]);
            mul_b      = MUL_W'(up_ff[kb]);
            itag.dst   = DST_C;
            itag.idx   = step_ff[2:1];
            itag.neg   = step_ff[0];
            itag.first = !step_ff[0];
            itag.last  = step_ff[0];
         end
         PROG_UVEC: begin
            nsteps = UVEC_STEPS;
            if (step_ff < 4'd6) begin
               mul_a      = MUL_W'(s_ff[ka]);
               mul_b      = MUL_W'(f_ff[kb]);
               itag.dst   = DST_U;
               itag.idx   = step_ff[2:1];
               itag.neg   = step_ff[0];
               itag.first = !step_ff[0];
               itag.last  = step_ff[0];
            end else begin
               if (step_ff < 4'd9) begin
                  kk       = 2'(step_ff - 4'd6);
                  mul_a    = MUL_W'(s_ff[kk]);
                  itag.idx = 2'd0;
               end else if (step_ff < 4'd12) begin
                  kk       = 2'(step_ff - 4'd9);
                  mul_a    = MUL_W'(f_ff[kk]);
                  itag.idx = 2'd2;
               end else begin
                  kk       = 2'(step_ff - 4'd12);
                  mul_a    = MUL_W'(u_ff[kk]);
                  itag.idx = 2'd1;
               end
               mul_b      = MUL_W'(eye_ff[kk]);
               itag.dst   = DST_T;
               itag.first = (kk == 2'd0);
               itag.last  = (kk == 2'd2);
            end
         end
         default: begin
            nsteps = SQ_STEPS;
         end
      endcase
   end

   assign mul_p    = mul_a * mul_b;
   assign base     = tag_ff.first ? '0 : acc_ff;
   assign acc_next = tag_ff.neg ? base - prod_ff : base + prod_ff;
   assign rnd      = round16(acc_next);
   assign rnd50    = 50'(rnd);
   assign or_all   = mag_ff[0] | mag_ff[1] | mag_ff[2];
   assign rb       = r_ff + b_ff;
   assign trial    = (NUM_W+1)'({17'b0, len_ff}) << qpos_ff;
   assign ge       = ({1'b0, rem_ff} >= trial);
   assign qn       = q_ff | (Q_W'(ge) << qpos_ff);
   assign oval     = neg_ff[comp_ff] ? VEC_W'(VEC_W'(0) - VEC_W'(qn)) : VEC_W'(qn);
   assign cnext    = comp_ff + 2'd1;

   always_comb begin
      state_in = state_ff;
      prog_in  = prog_ff;
      step_in  = step_ff;
      sel_in   = sel_ff;
      eye_in   = eye_ff;
      up_in    = up_ff;
      raw_in   = raw_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      f_in     = f_ff;
      s_in     = s_ff;
      u_in     = u_ff;
      t_in     = t_ff;
      deg_in   = deg_ff;
      n_in     = n_ff;
      r_in     = r_ff;
      b_in     = b_ff;
      len_in   = len_ff;
      comp_in  = comp_ff;
      qpos_in  = qpos_ff;
      rem_in   = rem_ff;
      q_in     = q_ff;
      prod_in  = mul_p[ACC_W-1:0];
      acc_in   = acc_ff;
      tag_in   = '0;
      item_pop = 1'b0;

      if (tag_ff.valid) begin
         acc_in = acc_next;
         if (tag_ff.last) begin
            case (tag_ff.dst)
               DST_SQ: n_in = acc_next[SQ_W-1:0];
               DST_C:  raw_in[tag_ff.idx] = acc_next[RAW_W-1:0];
               DST_U:  u_in[tag_ff.idx] = rnd[UVEC_W-1:0];
               DST_T: begin
                  case (tag_ff.idx)
                     2'd0:    t_in[0] = sat32(-rnd50);
                     2'd1:    t_in[1] = sat32(-rnd50);
                     default: t_in[2] = sat32(rnd50);
                  endcase
               end
               default: acc_in = acc_next;
            endcase
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               for (int i = 0; i < 3; i++) begin
                  eye_in[i] = item.eye[i];
                  up_in[i]  = item.up[i];
                  raw_in[i] = RAW_W'($signed(item.dvec[i]));
               end
               sel_in = 1'b0;
               if (item.dzero) begin
                  for (int i = 0; i < 3; i++) begin
                     f_in[i] = '0;
                     s_in[i] = '0;
                     u_in[i] = '0;
                     t_in[i] = '0;
                  end
                  deg_in   = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  deg_in   = 1'b0;
                  state_in = ST_NLOAD;
               end
            end
         end
         ST_NLOAD: begin
            for (int i = 0; i < 3; i++) begin
               neg_in[i] = raw_ff[i][RAW_W-1];
               mag_in[i] = raw_ff[i][RAW_W-1] ? RAW_W'(-raw_ff[i]) : RAW_W'(raw_ff[i]);
            end
            state_in = ST_NSHIFT;
         end
         ST_NSHIFT: begin
            if (or_all == '0) begin
               for (int i = 0; i < 3; i++) begin
                  if (sel_ff) begin
                     s_in[i] = '0;
                  end else begin
                     f_in[i] = '0;
                  end
               end
               deg_in   = 1'b1;
               state_in = ST_MAC;
               step_in  = '0;
               prog_in  = sel_ff ? PROG_UVEC : PROG_CROSS;
            end else if (|or_all[RAW_W-1:38]) begin
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] >> 8;
            end else if (|or_all[RAW_W-1:30]) begin
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] >> 1;
            end else if (!(|or_all[RAW_W-1:21])) begin
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] << 8;
            end else if (!(|or_all[RAW_W-1:29])) begin
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] << 1;
            end else begin
               state_in = ST_MAC;
               step_in  = '0;
               prog_in  = PROG_SQ;
            end
         end
         ST_MAC: begin
            if (step_ff < nsteps) begin
               tag_in       = itag;
               tag_in.valid = 1'b1;
               step_in      = step_ff + 1'b1;
            end else if (!tag_ff.valid) begin
               case (prog_ff)
                  PROG_SQ: begin
                     r_in     = '0;
                     b_in     = (SQ_W+1)'(1) << (SQ_W - 2 + 2);
                     state_in = ST_SQRT;
                  end
                  PROG_CROSS: begin
                     sel_in   = 1'b1;
                     state_in = ST_NLOAD;
                  end
                  PROG_UVEC: state_in = ST_DONE;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_SQRT: begin
            if (b_ff == '0) begin
               len_in   = r_ff[LEN_W-1:0];
               comp_in  = '0;
               qpos_in  = DIV_TOP;
               q_in     = '0;
               rem_in   = div_num(r_ff[LEN_W-1:0], mag_ff[0][MAG_W-1:0]);
               state_in = ST_DIV;
            end else begin
               if ({1'b0, n_ff} >= rb) begin
                  n_in = n_ff - rb[SQ_W-1:0];
                  r_in = (r_ff >> 1) + b_ff;
               end else begin
                  r_in = r_ff >> 1;
               end
               b_in = b_ff >> 2;
            end
         end
         ST_DIV: begin
            rem_in = ge ? rem_ff - trial[NUM_W-1:0] : rem_ff;
            q_in   = qn;
            if (qpos_ff == '0) begin
               if (sel_ff) begin
                  s_in[comp_ff] = oval;
               end else begin
                  f_in[comp_ff] = oval;
               end
               if (comp_ff == 2'd2) begin
                  state_in = ST_MAC;
                  step_in  = '0;
                  prog_in  = sel_ff ? PROG_UVEC : PROG_CROSS;
               end else begin
                  comp_in = cnext;
                  qpos_in = DIV_TOP;
                  q_in    = '0;
                  rem_in  = div_num(len_ff, mag_ff[cnext][MAG_W-1:0]);
               end
            end else begin
               qpos_in = qpos_ff - 1'b1;
            end
         end
         ST_DONE: begin
            if (mat_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tag_ff   <= '0;
      end else begin
         state_ff <= state_in;
         tag_ff   <= tag_in;
      end
   end

   always_ff @(posedge clock) begin
      prog_ff <= prog_in;
      step_ff <= step_in;
      sel_ff  <= sel_in;
      eye_ff  <= eye_in;
      up_ff   <= up_in;
      raw_ff  <= raw_in;
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      f_ff    <= f_in;
      s_ff    <= s_in;
      u_ff    <= u_in;
      t_ff    <= t_in;
      deg_ff  <= deg_in;
      n_ff    <= n_in;
      r_ff    <= r_in;
      b_ff    <= b_in;
      len_ff  <= len_in;
      comp_ff <= comp_in;
      qpos_ff <= qpos_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign mat_valid = (state_ff == ST_DONE);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mat.s[i] = s_ff[i];
         mat.u[i] = u_ff[i];
         mat.f[i] = f_ff[i];
         mat.t[i] = t_ff[i];
      end
      mat.deg = deg_ff;
   end

endmodule

// ----- hdl/lavm_rows.sv -----
`timescale 1ns / 1ps
// lavm_rows: output buffer holding one finished matrix and serving its four row transactions.
// Depends on lavm_pkg.
module lavm_rows (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 mat_valid,
   input  lavm_pkg::matrix_type mat,
   output logic                 mat_ready,
   output logic                 empty,
   input  logic                 pop,
   output lavm_pkg::rsp_type    rsp_data
);
   import lavm_pkg::*;

   matrix_type mat_ff, mat_in;
   logic       valid_ff, valid_in;
   logic [1:0] row_ff, row_in;

   assign mat_ready = !valid_ff || (pop && row_ff == LAST_ROW);
   assign empty     = !valid_ff;

   always_comb begin
      valid_in = valid_ff;
      row_in   = row_ff;
      mat_in   = mat_ff;
      if (mat_valid && mat_ready) begin
         valid_in = 1'b1;
         row_in   = '0;
         mat_in   = mat;
      end else if (pop && valid_ff) begin
         if (row_ff == LAST_ROW) begin
            valid_in = 1'b0;
         end else begin
            row_in = row_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         row_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         row_ff   <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      mat_ff <= mat_in;
   end

   always_comb begin
      rsp_data.row_index  = row_ff;
      rsp_data.last_row   = (row_ff == LAST_ROW);
      rsp_data.degenerate = mat_ff.deg;
      case (row_ff)
         2'd0, 2'd1, 2'd2: begin
            rsp_data.elem0 = ELEM_W'($signed(mat_ff.s[row_ff]));
            rsp_data.elem1 = ELEM_W'($signed(mat_ff.u[row_ff]));
            rsp_data.elem2 = -ELEM_W'($signed(mat_ff.f[row_ff]));
            rsp_data.elem3 = '0;
         end
         default: begin
            rsp_data.elem0 = mat_ff.t[0];
            rsp_data.elem1 = mat_ff.t[1];
            rsp_data.elem2 = mat_ff.t[2];
            rsp_data.elem3 = Q_ONE;
         end
      endcase
   end

endmodule

// ----- hdl/look_at_view_matrix_unit.sv -----
`timescale 1ns / 1ps
// look_at_view_matrix_unit: top level; front, transaction queue, engine and row buffer.
// Depends on lavm_pkg, lavm_front, lavm_queue, lavm_engine, lavm_rows.
//
// Builds a look-at view matrix in signed Q16.16 from eye, target and up and returns it as
// four row transactions (rows 0..3, last_row on row 3). A request is taken whenever the
// queue has room; the engine works one request at a time, through its two
// normalizations, each a 32-step square root and three 17-step divisions on the shared
// divider, plus about 30 multiply-accumulate steps on one shared multiplier. When up is
// zero or parallel to the view vector the second normalization is skipped. The four rows
// leave from their own buffer while the engine already works on the next request. A zero
// view vector skips the engine work and returns with degenerate set.
module look_at_view_matrix_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  lavm_pkg::req_type req_data,
   output logic              empty,
   input  logic              pop,
   output lavm_pkg::rsp_type rsp_data
);
   import lavm_pkg::*;

   localparam int ITEM_W = $bits(item_type);

   item_type    front_item, eng_item;
   logic        q_push, q_full, q_valid, q_pop;
   logic [ITEM_W-1:0] q_rd;
   matrix_type  mat;
   logic        mat_valid, mat_ready;

   lavm_front u_front (
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .q_push   (q_push),
      .q_item   (front_item),
      .q_full   (q_full)
   );

   lavm_queue #(
      .WIDTH (ITEM_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (q_push),
      .wr_data  (ITEM_W'(front_item)),
      .full     (q_full),
      .rd_valid (q_valid),
      .rd_data  (q_rd),
      .rd_pop   (q_pop)
   );

   assign eng_item = item_type'(q_rd);

   lavm_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .item_valid (q_valid),
      .item       (eng_item),
      .item_pop   (q_pop),
      .mat_valid  (mat_valid),
      .mat        (mat),
      .mat_ready  (mat_ready)
   );

   lavm_rows u_rows (
      .clock     (clock),
      .reset     (reset),
      .mat_valid (mat_valid),
      .mat       (mat),
      .mat_ready (mat_ready),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- sim/lavm_view_checker.sv -----
`timescale 1ns / 1ps
// lavm_view_checker: watches both channels of look_at_view_matrix_unit, predicts the
// four matrix rows of each accepted request and compares them in order. Uses lavm_pkg.
module lavm_view_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic              full,
   input  lavm_pkg::req_type req_data,
   input  logic              empty,
   input  logic              pop,
   input  lavm_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                rows_pending
);
   import lavm_pkg::*;

   rsp_type expected_rows[$];

   function automatic longint round_q16(input longint v);
      longint unsigned mag;
      mag = v < 0 ? -v : v;
      mag = (mag + 64'd32768) >> 16;
      return v < 0 ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic longint sat_q16(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic bit unit_vector(input longint v[3], output longint o[3]);
      longint unsigned m[3], top, sum, len;
      top = 0;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = v[i] < 0 ? -v[i] : v[i];
         if (m[i] > top) top = m[i];
      end
      if (top == 0) begin
         for (int i = 0; i < 3; i++) o[i] = 0;
         return 1'b0;
      end
      while (top >= (64'd1 << 30)) begin
         top = top >> 1;
         for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
      end
      while (top < (64'd1 << 29)) begin
         top = top << 1;
         for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
      end
      for (int i = 0; i < 3; i++) sum += m[i] * m[i];
      len = int_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
         o[i] = longint'(((m[i] << 16) + (len >> 1)) / len);
         if (v[i] < 0) o[i] = -o[i];
      end
      return 1'b1;
   endfunction

   function automatic void cross_prod(input longint a[3], input longint b[3],
                                      output longint o[3]);
      o[0] = a[1] * b[2] - a[2] * b[1];
      o[1] = a[2] * b[0] - a[0] * b[2];
      o[2] = a[0] * b[1] - a[1] * b[0];
   endfunction

   function automatic longint dot_prod(input longint a[3], input longint b[3]);
      return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
   endfunction

   task automatic predict_view_rows(input req_type r);
      longint eye[3], tgt[3], upv[3], d[3], f[3], c[3], s[3], uf[3], u[3];
      longint m[4][4];
      bit deg;
      rsp_type row;
      eye = '{longint'(r.eye_x), longint'(r.eye_y), longint'(r.eye_z)};
      tgt = '{longint'(r.target_x), longint'(r.target_y), longint'(r.target_z)};
      upv = '{longint'(r.up_x), longint'(r.up_y), longint'(r.up_z)};
      for (int i = 0; i < 3; i++) d[i] = tgt[i] - eye[i];
      deg = !unit_vector(d, f);
      cross_prod(f, upv, c);
      if (!unit_vector(c, s)) deg = 1'b1;
      cross_prod(s, f, uf);
      for (int i = 0; i < 3; i++) u[i] = round_q16(uf[i]);
      for (int i = 0; i < 3; i++) begin
         m[i][0] = s[i];
         m[i][1] = u[i];
         m[i][2] = -f[i];
         m[i][3] = 0;
      end
      m[3][0] = sat_q16(-round_q16(dot_prod(s, eye)));
      m[3][1] = sat_q16(-round_q16(dot_prod(u, eye)));
      m[3][2] = sat_q16(round_q16(dot_prod(f, eye)));
      m[3][3] = longint'(Q_ONE);
      for (int i = 0; i < 4; i++) begin
         row.row_index  = 2'(i);
         row.elem0      = m[i][0][31:0];
         row.elem1      = m[i][1][31:0];
         row.elem2      = m[i][2][31:0];
         row.elem3      = m[i][3][31:0];
         row.last_row   = (2'(i) == LAST_ROW);
         row.degenerate = deg;
         expected_rows.push_back(row);
      end
   endtask

   assign rows_pending = expected_rows.size();

   initial fail_count = 0;

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (push && !full) predict_view_rows(req_data);
         if (pop && !empty) begin
            if (expected_rows.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected row transaction: %p", rsp_data);
            end else begin
               want = expected_rows.pop_front();
               if (rsp_data.row_index !== want.row_index || rsp_data.elem0 !== want.elem0 ||
                   rsp_data.elem1 !== want.elem1 || rsp_data.elem2 !== want.elem2 ||
                   rsp_data.elem3 !== want.elem3 || rsp_data.last_row !== want.last_row ||
                   rsp_data.degenerate !== want.degenerate) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("row mismatch: expected %p actual %p", want, rsp_data);
               end
            end
         end
      end
   end
endmodule

// ----- sim/look_at_view_matrix_unit_tb.sv -----
`timescale 1ns / 1ps
// look_at_view_matrix_unit_tb: drives directed and random view requests with random
// idling on both channels. Depends on lavm_pkg, look_at_view_matrix_unit, lavm_view_checker.
module look_at_view_matrix_unit_tb;
   import lavm_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int RANDOM_ITEMS = 230;

   logic    clock;
   logic    reset;
   logic    push;
   logic    full;
   req_type req_data;
   logic    empty;
   logic    pop;
   rsp_type rsp_data;
   int      fail_count;
   int      rows_pending;
   bit      quiet_phase;
   int      cycle_count;

   look_at_view_matrix_unit dut (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_data(req_data),
      .empty(empty), .pop(pop), .rsp_data(rsp_data)
   );

   lavm_view_checker checker_i (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_data(req_data),
      .empty(empty), .pop(pop), .rsp_data(rsp_data), .fail_count(fail_count),
      .rows_pending(rows_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // result side stalls
   initial begin
      int stall;
      pop = 1'b0;
      forever begin
         @(negedge clock);
         if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 14);
            pop = 1'b0;
            repeat (stall - 1) @(negedge clock);
         end else begin
            pop = 1'b1;
         end
      end
   end

   // full is stable between rising edges, so it is checked at the falling edge
   task automatic send_view(input req_type r);
      push = 1'b1;
      req_data = r;
      while (full) @(negedge clock);
      @(negedge clock);
      push = 1'b0;
      if (!quiet_phase && $urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 14)) @(negedge clock);
   endtask

   function automatic req_type make_view(input int ex, ey, ez, tx, ty, tz,
                                         input int ux, uy, uz);
      req_type r;
      r = '{ex, ey, ez, tx, ty, tz, ux, uy, uz};
      return r;
   endfunction

   function automatic int scene_coord();
      int v;
      case ($urandom_range(0, 9))
         0:       v = $urandom();
         1:       v = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
         2:       v = int'($urandom_range(0, 7)) - 3;
         default: v = int'($urandom_range(0, 32'h00ffffff)) - 32'h00800000;
      endcase
      return v;
   endfunction

   initial begin
      req_type r;
      int dx, dy, dz;
      localparam int ONE = 32'h00010000;
      localparam int MAXV = 32'h7fffffff;
      localparam int MINV = 32'h80000000;
      push = 1'b0;
      req_data = '0;
      quiet_phase = 1'b0;
      reset = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_view(make_view(0, 0, 5*ONE, 0, 0, 0, 0, ONE, 0));
      send_view(make_view(ONE, 2*ONE, 3*ONE, ONE, 2*ONE, 3*ONE, 0, ONE, 0));
      send_view(make_view(0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_view(make_view(0, 0, 0, 0, 0, -ONE, 0, 0, 0));
      send_view(make_view(0, 0, 0, 0, 0, -ONE, 0, 0, ONE));
      send_view(make_view(0, 0, 0, 0, 3*ONE, 0, 0, -7*ONE, 0));
      send_view(make_view(MAXV, MAXV, MAXV, MINV, MINV, MINV, MAXV, MINV, 0));
      send_view(make_view(MINV, MINV, MINV, MAXV, MAXV, MAXV, MINV, MAXV, MAXV));
      send_view(make_view(MAXV, MINV, MAXV, MINV, MAXV, MINV, 0, 0, MINV));
      send_view(make_view(MINV, MAXV, 0, MAXV, MINV, 1, MAXV, MAXV, MINV));
      send_view(make_view(MAXV, 0, 0, 0, MAXV, 0, 0, 0, MAXV));
      send_view(make_view(MINV, 0, MINV, 0, 0, 0, 1, 0, 0));
      send_view(make_view(0, 0, 0, 1, 0, 0, 0, 1, 0));
      send_view(make_view(0, 0, 0, 1, 1, 1, -1, 1, -1));
      send_view(make_view(-1, -1, -1, 0, 0, 0, 1, 1, 1));
      send_view(make_view(10*ONE, -4*ONE, 7*ONE, -3*ONE, 2*ONE, ONE, ONE, ONE, 0));
      send_view(make_view(-1, 0, 0, -1, 0, 0, -1, -1, -1));

      // hold off until the block has drained
      wait (rows_pending == 0);
      @(negedge clock);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS - 40) quiet_phase = 1'b1;
         r = make_view(scene_coord(), scene_coord(), scene_coord(), scene_coord(),
                       scene_coord(), scene_coord(), scene_coord(), scene_coord(),
                       scene_coord());
         case ($urandom_range(0, 15))
            0: begin
               r.target_x = r.eye_x;
               r.target_y = r.eye_y;
               r.target_z = r.eye_z;
            end
            1: begin
               dx = int'($urandom_range(0, 2000)) - 1000;
               dy = int'($urandom_range(0, 2000)) - 1000;
               dz = int'($urandom_range(0, 2000)) - 1000;
               r.eye_x = int'($urandom_range(0, 32'h0fffffff)) - 32'h08000000;
               r.target_x = r.eye_x + dx * 256;
               r.target_y = r.eye_y;
               r.target_z = r.eye_z;
               r.eye_y = r.target_y - dy * 256;
               r.eye_z = r.target_z - dz * 256;
               r.up_x = dx * 3;
               r.up_y = dy * 3;
               r.up_z = dz * 3;
            end
            2: {r.up_x, r.up_y, r.up_z} = '0;
            default: ;
         endcase
         send_view(r);
      end

      fork
         begin
            wait (rows_pending == 0);
            repeat (300) @(posedge clock);
         end
         begin
            repeat (100000) @(posedge clock);
         end
      join_any
      if (fail_count == 0 && rows_pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule

// ----- sim.f -----
hdl/lavm_pkg.sv
hdl/lavm_front.sv
hdl/lavm_queue.sv
hdl/lavm_engine.sv
hdl/lavm_rows.sv
hdl/look_at_view_matrix_unit.sv
sim/lavm_view_checker.sv
sim/look_at_view_matrix_unit_tb.sv
